### hdl/neighbor_copy_dilation_defines.svh
// ============================================================================
// Assertion macros for the neighbor copy dilation block
// Shared property forms. Each use expects clk and arst_n in scope.
// ============================================================================
`ifndef NEIGHBOR_COPY_DILATION_DEFINES_SVH
`define NEIGHBOR_COPY_DILATION_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define NCD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ncd_pkg.sv
// ============================================================================
// ncd_pkg
// Widths, register codes and the word type that moves along the cell chain.
// ============================================================================
`default_nettype none

package ncd_pkg;

	localparam int PIXEL_W    = 32;
	localparam int BLUE_W     = 8;
	localparam int IMG_W_W    = 12;
	localparam int IMG_H_W    = 13;
	localparam int CFG_DATA_W = 13;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [IMG_W_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [IMG_H_W-1:0] HEIGHT_RST = 13'd480;

	// Neighbor slots in priority order; one cell per slot.
	localparam int NUM_CAND   = 4;
	localparam int NUM_CELLS  = NUM_CAND;
	localparam int CAND_UP    = 0;
	localparam int CAND_LEFT  = 1;
	localparam int CAND_RIGHT = 2;
	localparam int CAND_DOWN  = 3;

	typedef struct packed {
		logic [NUM_CAND-1:0][PIXEL_W-1:0] cand;
		logic [NUM_CAND-1:0]              cand_en;
		logic [PIXEL_W-1:0]               result;
		logic                             found;
		logic                             row_end;
		logic                             frame_end;
	} ncd_word_t;

endpackage

`default_nettype wire

### hdl/ncd_line_buf.sv
// ============================================================================
// ncd_line_buf
// One-row pixel store: one write port, two registered read ports with
// write-through on an address match.
// ============================================================================
`default_nettype none

module ncd_line_buf #(
	parameter int AW = 11,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] wa,
	input  wire logic [DW-1:0] wd,
	input  wire logic [AW-1:0] ra0,
	input  wire logic [AW-1:0] ra1,
	output logic      [DW-1:0] rd0,
	output logic      [DW-1:0] rd1
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rd0_q;
	logic [DW-1:0] rd1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		// pass the word being written straight to a read of the same entry
		rd0_q <= (we && (wa == ra0)) ? wd : mem[ra0];
		rd1_q <= (we && (wa == ra1)) ? wd : mem[ra1];
	end

	assign rd0 = rd0_q;
	assign rd1 = rd1_q;

endmodule

`default_nettype wire

### hdl/ncd_cell.sv
// ============================================================================
// ncd_cell
// One step of the neighbor priority chain: test the head candidate, shift
// the rest down, register the word and hand it to the next cell.
// ============================================================================
`default_nettype none

module ncd_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ncd_pkg::ncd_word_t in_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ncd_pkg::ncd_word_t     out_word
);

	import ncd_pkg::*;

	logic      valid_s1;
	ncd_word_t word_s1;
	ncd_word_t word_next;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		word_next = in_word;
		for (int i = 0; i < NUM_CAND - 1; i++) begin
			word_next.cand[i]    = in_word.cand[i+1];
			word_next.cand_en[i] = in_word.cand_en[i+1];
		end
		word_next.cand[NUM_CAND-1]    = '0;
		word_next.cand_en[NUM_CAND-1] = 1'b0;
		// first qualifying neighbor wins; later cells see found set
		if (!in_word.found && in_word.cand_en[0] && (in_word.cand[0][BLUE_W-1:0] != '0)) begin
			word_next.result = in_word.cand[0];
			word_next.found  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= word_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

`default_nettype wire

### hdl/neighbor_copy_dilation.sv
// ============================================================================
// neighbor_copy_dilation
// Four-neighbor dilation of an ARGB raster stream, one row behind the input.
// ============================================================================
// Usage:
//   Feed the frame row by row on in_valid/in_ready (pixel_in, is_padding),
//   then one padding row. Each word of input row r yields the output word for
//   the same column of row r-1; row 0 yields nothing. pixel_out takes the
//   first neighbor (up, left, right, down) inside the image with a nonzero
//   blue byte, else the pixel itself. row_end and frame_end mark the last
//   word of a row and of the frame.
//   Throughput is one word per clock while in_ready is high. Each emitted
//   word passes through the four neighbor cells, each of which registers it.
//   The two line buffers are read one word ahead at the next column, so
//   in_ready drops after reset and after each write on the configuration
//   port while those read registers refetch.
//   Reset clears the counters and the chain, and loads width 640 and height
//   480; the line buffers are not cleared. When out_ready is low the chain
//   fills up cell by cell and in_ready falls only once the first cell holds.
// ============================================================================
`default_nettype none

`include "neighbor_copy_dilation_defines.svh"

module neighbor_copy_dilation #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [ncd_pkg::REG_IDX_W-1:0]   wr_index,
	input  wire logic [ncd_pkg::CFG_DATA_W-1:0]  wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ncd_pkg::PIXEL_W-1:0]     pixel_in,
	input  wire logic                            is_padding,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [ncd_pkg::PIXEL_W-1:0]     pixel_out,
	output logic                                 row_end,
	output logic                                 frame_end
);

	import ncd_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = (WW > IMG_W_W) ? WW : IMG_W_W;

	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	logic               fetch_ok_q;
	logic [AW-1:0]      col_q;
	logic [IMG_H_W-1:0] row_q;

	logic [CW-1:0]      w_ext;
	logic [CW-1:0]      w_eff;
	logic [AW-1:0]      col_last;
	logic [IMG_H_W-1:0] h_eff;
	logic [AW-1:0]      x;
	logic [AW-1:0]      nx;
	logic               last_col;
	logic               flush_row;
	logic               emit;
	logic               accept;

	logic [PIXEL_W-1:0] up_rd;
	logic [PIXEL_W-1:0] left_rd;
	logic [PIXEL_W-1:0] here_rd;
	logic [PIXEL_W-1:0] right_rd;

	logic [NUM_CELLS:0] stage_valid;
	logic [NUM_CELLS:0] stage_ready;
	ncd_word_t          stage_word [NUM_CELLS+1];

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			fetch_ok_q <= 1'b0;
		end else begin
			// refetch the read registers after any write
			fetch_ok_q <= !wr_en;
			if (wr_en) begin
				case (wr_index)
					REG_IMAGE_WIDTH: begin
						width_q <= wr_data[IMG_W_W-1:0];
					end
					REG_IMAGE_HEIGHT: begin
						height_q <= wr_data[IMG_H_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		w_ext = CW'(width_q);
		if (w_ext == '0) begin
			w_eff = CW'(1);
		end else if (w_ext > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
	end

	assign col_last = AW'(w_eff - CW'(1));
	assign h_eff    = (height_q == '0) ? IMG_H_W'(1) : height_q;

	// ---------------- position counters ----------------
	assign x         = (col_q >= col_last) ? col_last : col_q;
	assign last_col  = (x == col_last);
	assign flush_row = (row_q >= h_eff);
	assign emit      = (row_q != '0);

	assign in_ready = fetch_ok_q && stage_ready[0];
	assign accept   = in_valid && in_ready;

	// column of the word that will be pending next cycle
	assign nx = accept ? (last_col ? '0 : x + AW'(1)) : x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= flush_row ? '0 : row_q + IMG_H_W'(1);
			end else begin
				col_q <= x + AW'(1);
			end
		end
	end

	// ---------------- line buffers ----------------
	ncd_line_buf #(
		.AW (AW),
		.DW (PIXEL_W)
	) u_older (
		.clk (clk),
		.we  (accept),
		.wa  (x),
		.wd  (here_rd),
		.ra0 (nx),
		.ra1 (nx - AW'(1)),
		.rd0 (up_rd),
		.rd1 (left_rd)
	);

	ncd_line_buf #(
		.AW (AW),
		.DW (PIXEL_W)
	) u_middle (
		.clk (clk),
		.we  (accept),
		.wa  (x),
		.wd  (pixel_in),
		.ra0 (nx),
		.ra1 (nx + AW'(1)),
		.rd0 (here_rd),
		.rd1 (right_rd)
	);

	// ---------------- neighbor chain ----------------
	always_comb begin
		stage_word[0]                    = '0;
		stage_word[0].cand[CAND_UP]      = up_rd;
		stage_word[0].cand[CAND_LEFT]    = left_rd;
		stage_word[0].cand[CAND_RIGHT]   = right_rd;
		stage_word[0].cand[CAND_DOWN]    = pixel_in;
		stage_word[0].cand_en[CAND_UP]   = (row_q >= IMG_H_W'(2));
		stage_word[0].cand_en[CAND_LEFT] = (x != '0);
		stage_word[0].cand_en[CAND_RIGHT] = !last_col;
		stage_word[0].cand_en[CAND_DOWN] = !is_padding && !flush_row;
		stage_word[0].result             = here_rd;
		stage_word[0].found              = 1'b0;
		stage_word[0].row_end            = last_col;
		stage_word[0].frame_end          = last_col && flush_row;
	end

	// row 0 words only fill the buffers
	assign stage_valid[0]         = accept && emit;
	assign stage_ready[NUM_CELLS] = out_ready;

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		ncd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[g]),
			.in_ready  (stage_ready[g]),
			.in_word   (stage_word[g]),
			.out_valid (stage_valid[g+1]),
			.out_ready (stage_ready[g+1]),
			.out_word  (stage_word[g+1])
		);
	end

	assign out_valid = stage_valid[NUM_CELLS];
	assign pixel_out = stage_word[NUM_CELLS].result;
	assign row_end   = stage_word[NUM_CELLS].row_end;
	assign frame_end = stage_word[NUM_CELLS].frame_end;

	// ---------------- assertions ----------------
	`NCD_ASSERT_NEXT(a_refetch_after_cfg, wr_en, !in_ready, "ready high right after a config write")
	`NCD_ASSERT_NEXT(a_emit_enters_chain, accept && emit, stage_valid[1], "emitting word lost at chain entry")
	`NCD_ASSERT_NEXT(a_col_in_range, accept && !wr_en, col_q <= col_last, "column counter past last column")
	`NCD_ASSERT_SAME(a_frame_end_row_end, out_valid && frame_end, row_end, "frame end without row end")

endmodule

`default_nettype wire
